>>> rtl/srq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srq_pkg;

  // Default sizing of the queue.
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int KEY_BITS_DEF    = 32;

  // Fixed widths of the transaction fields.
  localparam int OP_W   = 2;
  localparam int PID_W  = 6;
  localparam int DIST_W = 32;

  // Operation codes carried by an input transaction.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  // Command classes handed from the front end to the engine.
  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_FLUSH,
    CMD_NOP
  } cmd_kind_t;

  // One classified command.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [PID_W-1:0]  proc_id;
    logic              mlfq_flag;
    logic [DIST_W-1:0] distance;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/srq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module srq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/srq_front.sv
`timescale 1ns / 1ps
`default_nettype none

module srq_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [srq_pkg::OP_W-1:0]  in_operation,
  input  wire logic [srq_pkg::PID_W-1:0] in_proc_id,
  input  wire logic                      in_mlfq_flag,
  input  wire logic [srq_pkg::DIST_W-1:0] in_distance,
  output logic                           cmd_valid,
  output srq_pkg::cmd_t                  cmd,
  input  wire logic                      cmd_take
);
  import srq_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  cmd_t       new_cmd;
  logic       push;
  logic       pop;

  // Decode the operation code into a command class.
  always_comb begin
    new_cmd.proc_id   = in_proc_id;
    new_cmd.mlfq_flag = in_mlfq_flag;
    new_cmd.distance  = in_distance;
    case (op_t'(in_operation))
      OP_PUSH:  new_cmd.kind = CMD_PUSH;
      OP_POP:   new_cmd.kind = CMD_POP;
      OP_FLUSH: new_cmd.kind = CMD_FLUSH;
      default:  new_cmd.kind = CMD_NOP;
    endcase
  end

  // Two-entry command queue between the front end and the engine.
  assign in_ready  = (fill_r != 2'd2);
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_take && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Command payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/srq_back.sv
`timescale 1ns / 1ps
`default_nettype none

module srq_back #(
  parameter int QUEUE_DEPTH = srq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_BITS    = srq_pkg::KEY_BITS_DEF,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       queue_mode,
  input  wire logic                       cmd_valid,
  input  wire srq_pkg::cmd_t              cmd,
  output logic                            cmd_take,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_head_valid,
  output logic [srq_pkg::PID_W-1:0]       out_head_proc_id,
  output logic                            out_head_mlfq_flag,
  output logic [srq_pkg::DIST_W-1:0]      out_head_distance,
  output logic                            out_is_empty,
  output logic [CNT_W-1:0]                out_occupancy,
  output logic                            out_status
);
  import srq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int SUM_W = CNT_W + 1;
  localparam int ENT_W = PID_W + 1 + KEY_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SH_RD,
    S_SH_WR,
    S_INS
  } state_t;

  typedef struct packed {
    logic [PID_W-1:0]    proc_id;
    logic                mlfq_flag;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  state_t              state_r, state_nxt;
  cmd_kind_t           kind_r, kind_nxt;
  entry_t              new_r, new_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                hv_r, hv_nxt;
  logic [PID_W-1:0]    hp_r, hp_nxt;
  logic                hf_r, hf_nxt;
  logic [DIST_W-1:0]   hk_r, hk_nxt;
  logic                empty_r, empty_nxt;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic                status_r, status_nxt;

  logic                ram_wr_en;
  logic [IDX_W-1:0]    ram_wr_addr;
  logic [ENT_W-1:0]    ram_wr_data;
  logic                ram_rd_en;
  logic [IDX_W-1:0]    ram_rd_addr;
  logic [ENT_W-1:0]    ram_rd_data;
  entry_t              rd_ent;
  entry_t              in_ent;
  logic                done;

  // Map a logical position (0 is the head) to a slot of the circular store.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(pos);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  srq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_ent             = entry_t'(ram_rd_data);
  assign in_ent.proc_id     = cmd.proc_id;
  assign in_ent.mlfq_flag   = cmd.mlfq_flag;
  assign in_ent.key         = KEY_BITS'(cmd.distance);

  assign out_valid          = out_valid_r;
  assign out_head_valid     = hv_r;
  assign out_head_proc_id   = hp_r;
  assign out_head_mlfq_flag = hf_r;
  assign out_head_distance  = hk_r;
  assign out_is_empty       = empty_r;
  assign out_occupancy      = occ_r;
  assign out_status         = status_r;

  // Sequencer: one command at a time, result held until taken.
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    new_nxt       = new_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    hv_nxt        = hv_r;
    hp_nxt        = hp_r;
    hf_nxt        = hf_r;
    hk_nxt        = hk_r;
    empty_nxt     = empty_r;
    occ_nxt       = occ_r;
    status_nxt    = status_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = '0;
    ram_wr_data   = '0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = '0;
    cmd_take      = 1'b0;
    done          = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && !out_valid_r) begin
          cmd_take   = 1'b1;
          kind_nxt   = cmd.kind;
          new_nxt    = in_ent;
          hv_nxt     = 1'b0;
          hp_nxt     = '0;
          hf_nxt     = 1'b0;
          hk_nxt     = '0;
          status_nxt = 1'b0;
          case (cmd.kind)
            CMD_PUSH: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                status_nxt = 1'b1;
                done       = 1'b1;
              end else if (queue_mode || count_r == '0) begin
                // Append at the tail.
                ram_wr_en   = 1'b1;
                ram_wr_addr = phys(head_r, count_r);
                ram_wr_data = ENT_W'(in_ent);
                count_nxt   = count_r + 1'b1;
                done        = 1'b1;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SCAN_RD;
              end
            end
            CMD_POP, CMD_FLUSH: begin
              if (count_r == '0) begin
                done = 1'b1;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = head_r;
                state_nxt   = S_HEAD;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      // Head entry is on the read port.
      S_HEAD: begin
        hv_nxt = 1'b1;
        hp_nxt = rd_ent.proc_id;
        hf_nxt = rd_ent.mlfq_flag;
        hk_nxt = DIST_W'(rd_ent.key);
        if (kind_r == CMD_POP) begin
          head_nxt  = phys(head_r, CNT_W'(1));
          count_nxt = count_r - 1'b1;
        end else begin
          count_nxt = '0;
        end
        done = 1'b1;
      end

      // Search from the head for the first key above the new one.
      S_SCAN_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = phys(head_r, idx_r);
        state_nxt   = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (rd_ent.key > new_r.key) begin
          pos_nxt   = idx_r;
          idx_nxt   = count_r - 1'b1;
          state_nxt = S_SH_RD;
        end else if (idx_r == count_r - 1'b1) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = phys(head_r, count_r);
          ram_wr_data = ENT_W'(new_r);
          count_nxt   = count_r + 1'b1;
          done        = 1'b1;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end

      // Move entries one place towards the tail, from the tail down.
      S_SH_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = phys(head_r, idx_r);
        state_nxt   = S_SH_WR;
      end

      S_SH_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = phys(head_r, idx_r + 1'b1);
        ram_wr_data = ram_rd_data;
        if (idx_r == pos_r) begin
          state_nxt = S_INS;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_SH_RD;
        end
      end

      S_INS: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = phys(head_r, pos_r);
        ram_wr_data = ENT_W'(new_r);
        count_nxt   = count_r + 1'b1;
        done        = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Load the result register when a command completes.
    if (done) begin
      out_valid_nxt = 1'b1;
      occ_nxt       = count_nxt;
      empty_nxt     = (count_nxt == '0);
      state_nxt     = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r   <= kind_nxt;
    new_r    <= new_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    hv_r     <= hv_nxt;
    hp_r     <= hp_nxt;
    hf_r     <= hf_nxt;
    hk_r     <= hk_nxt;
    empty_r  <= empty_nxt;
    occ_r    <= occ_nxt;
    status_r <= status_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/stride_or_fifo_ready_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A transaction waits in the command queue until the engine takes it; pop and flush read
// the head entry and then complete, a FIFO-mode push or a dropped push completes from idle,
// and a stride-mode push scans, shifts and inserts through the one-read, one-write store.
// Throughput: one transaction at a time in the engine; two more may wait in the queue.
// Reset (synchronous, active low) empties the queue and selects stride mode.
module stride_or_fifo_ready_queue_core #(
  parameter int QUEUE_DEPTH = srq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_BITS    = srq_pkg::KEY_BITS_DEF,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [srq_pkg::OP_W-1:0]    in_operation,
  input  wire logic [srq_pkg::PID_W-1:0]   in_proc_id,
  input  wire logic                        in_mlfq_flag,
  input  wire logic [srq_pkg::DIST_W-1:0]  in_distance,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_head_valid,
  output logic [srq_pkg::PID_W-1:0]        out_head_proc_id,
  output logic                             out_head_mlfq_flag,
  output logic [srq_pkg::DIST_W-1:0]       out_head_distance,
  output logic                             out_is_empty,
  output logic [CNT_W-1:0]                 out_occupancy,
  output logic                             out_status,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_data
);
  import srq_pkg::*;

  logic mode_r, mode_nxt;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  // Mode register; writes are always taken.
  assign cfg_ready = 1'b1;
  assign mode_nxt  = (cfg_valid && cfg_ready) ? cfg_data : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  srq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_proc_id   (in_proc_id),
    .in_mlfq_flag (in_mlfq_flag),
    .in_distance  (in_distance),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  srq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .queue_mode         (mode_r),
    .cmd_valid          (cmd_valid),
    .cmd                (cmd),
    .cmd_take           (cmd_take),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_head_valid     (out_head_valid),
    .out_head_proc_id   (out_head_proc_id),
    .out_head_mlfq_flag (out_head_mlfq_flag),
    .out_head_distance  (out_head_distance),
    .out_is_empty       (out_is_empty),
    .out_occupancy      (out_occupancy),
    .out_status         (out_status)
  );

endmodule

`default_nettype wire

>>> rtl/srq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module srq_checker #(
  parameter int QUEUE_DEPTH = srq_pkg::QUEUE_DEPTH_DEF,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       out_head_valid,
  input wire logic [srq_pkg::PID_W-1:0]  out_head_proc_id,
  input wire logic                       out_head_mlfq_flag,
  input wire logic [srq_pkg::DIST_W-1:0] out_head_distance,
  input wire logic                       out_is_empty,
  input wire logic [CNT_W-1:0]           out_occupancy,
  input wire logic                       out_status
);

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // A stalled result transaction keeps its distance, occupancy and status.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_head_distance)
      && $stable(out_occupancy) && $stable(out_status))
    else $error("stalled result changed");

  // The empty flag agrees with the occupancy.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  // Without a returned entry the entry fields read zero.
  a_zero_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_head_valid |-> out_head_proc_id == '0
      && !out_head_mlfq_flag && out_head_distance == '0)
    else $error("entry fields set without a returned entry");

  // A dropped push leaves a full queue and returns no entry.
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_head_valid
      && out_occupancy == CNT_W'(QUEUE_DEPTH))
    else $error("dropped push with a free slot or a returned entry");

endmodule

bind stride_or_fifo_ready_queue_core srq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_srq_checker (.*);

`default_nettype wire
